>>> hw/rtl/tpsp_pkg.sv
// tpsp_pkg: shared constants, codes and structs for the token pair sequence packer.
// No dependencies; imported by every module of the block.
package tpsp_pkg;

  localparam int MAX_ROW        = 4096;
  localparam int DEFAULT_LENGTH = 512;

  localparam int TOK_W   = 32;  // token id width
  localparam int CNT_W   = 16;  // count width of the start transaction
  localparam int LEN_W   = 13;  // row length / kept count / position counter width
  localparam int OPOS_W  = 12;  // position width on the result channel
  localparam int MODE_W  = 2;
  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 3;   // configuration register index width
  localparam int NSLOT   = 3;   // row entries one input transaction can cause

  localparam logic [LEN_W-1:0] MAX_ROW_L     = LEN_W'(MAX_ROW);
  localparam logic [CNT_W-1:0] DEFAULT_LEN_L = CNT_W'(DEFAULT_LENGTH);
  localparam logic [LEN_W-1:0] MARKER_SLOTS  = LEN_W'(3);

  // Input commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOC   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PAD   = 2'd3;

  // Truncation modes (the fourth code behaves as longest first)
  localparam logic [MODE_W-1:0] TRUNC_FAIL    = 2'd0;
  localparam logic [MODE_W-1:0] TRUNC_QUERY   = 2'd1;
  localparam logic [MODE_W-1:0] TRUNC_LONGEST = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ROW_CAPACITY = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SEQ_LIMIT    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TRUNC_MODE   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CLS_TOKEN    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SEP_TOKEN    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]  RST_ROW_CAPACITY = 13'd512;
  localparam logic [CNT_W-1:0]  RST_SEQ_LIMIT    = 16'd0;
  localparam logic [MODE_W-1:0] RST_TRUNC_MODE   = TRUNC_LONGEST;
  localparam logic [TOK_W-1:0]  RST_CLS_TOKEN    = 32'd101;
  localparam logic [TOK_W-1:0]  RST_SEP_TOKEN    = 32'd102;

  typedef struct packed {
    logic [LEN_W-1:0]  row_capacity;
    logic [CNT_W-1:0]  seq_limit;
    logic [MODE_W-1:0] trunc_mode;
    logic [TOK_W-1:0]  cls_token;
    logic [TOK_W-1:0]  sep_token;
  } tpsp_cfg_t;

  // One row entry
  typedef struct packed {
    logic [TOK_W-1:0]  token;
    logic              attend;
    logic              segment;
    logic [OPOS_W-1:0] position;
    logic              row_done;
  } tpsp_slot_t;

  // Row entries caused by one input transaction; slot 0 is the token itself,
  // slot 1 the query separator, slot 2 the closing separator.
  typedef struct packed {
    logic [NSLOT-1:0]             mask;
    tpsp_slot_t [NSLOT-1:0]       slot;
    logic                         status;
    logic [LEN_W-1:0]             packed_length;
  } tpsp_group_t;

endpackage

>>> hw/rtl/tpsp_cfg_regs.sv
// tpsp_cfg_regs: configuration register file of the packer.
// Depends on tpsp_pkg.
module tpsp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpsp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [tpsp_pkg::TOK_W-1:0]   cfg_data,
  output tpsp_pkg::tpsp_cfg_t          cfg
);
  import tpsp_pkg::*;

  tpsp_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_capacity <= RST_ROW_CAPACITY;
      cfg_r.seq_limit    <= RST_SEQ_LIMIT;
      cfg_r.trunc_mode   <= RST_TRUNC_MODE;
      cfg_r.cls_token    <= RST_CLS_TOKEN;
      cfg_r.sep_token    <= RST_SEP_TOKEN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_CAPACITY: cfg_r.row_capacity <= cfg_data[LEN_W-1:0];
        REG_SEQ_LIMIT:    cfg_r.seq_limit    <= cfg_data[CNT_W-1:0];
        REG_TRUNC_MODE:   cfg_r.trunc_mode   <= cfg_data[MODE_W-1:0];
        REG_CLS_TOKEN:    cfg_r.cls_token    <= cfg_data;
        REG_SEP_TOKEN:    cfg_r.sep_token    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/tpsp_frame.sv
// tpsp_frame: pair state and the single-pass framing logic that turns one
// input transaction into up to three row entries. Depends on tpsp_pkg.
module tpsp_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpsp_pkg::tpsp_cfg_t         cfg,
  input  logic                        advance,
  input  logic [tpsp_pkg::CMD_W-1:0]  cmd,
  input  logic [tpsp_pkg::TOK_W-1:0]  token_value,
  input  logic [tpsp_pkg::CNT_W-1:0]  query_count,
  input  logic [tpsp_pkg::CNT_W-1:0]  doc_count,
  output tpsp_pkg::tpsp_group_t       group
);
  import tpsp_pkg::*;

  logic             pair_active_r, pair_active_nxt;
  logic             sep_done_r, sep_done_nxt;
  logic [LEN_W-1:0] query_kept_r, query_kept_nxt, doc_kept_r, doc_kept_nxt;
  logic [CNT_W-1:0] query_seen_r, query_seen_nxt, doc_seen_r, doc_seen_nxt;
  logic [CNT_W-1:0] query_total_r, query_total_nxt, doc_total_r, doc_total_nxt;
  logic [LEN_W-1:0] next_pos_r, next_pos_nxt, row_len_r, row_len_nxt;

  function automatic logic at_row_end(input logic [LEN_W-1:0] p,
                                      input logic [LEN_W-1:0] rl);
    return (rl != '0) && (p == rl - LEN_W'(1));
  endfunction

  always_comb begin
    logic [LEN_W-1:0] rc, cap, budget, half, kq, kd;
    logic [CNT_W-1:0] want;
    logic [CNT_W:0]   sum;
    logic             over, fail, e0, mk, m1, m2, sep_pre;
    logic [TOK_W-1:0] tok0;
    logic             att0, seg0;
    logic [LEN_W-1:0] p0, p1, p2;

    pair_active_nxt = pair_active_r;
    sep_done_nxt    = sep_done_r;
    query_kept_nxt  = query_kept_r;
    doc_kept_nxt    = doc_kept_r;
    query_seen_nxt  = query_seen_r;
    doc_seen_nxt    = doc_seen_r;
    query_total_nxt = query_total_r;
    doc_total_nxt   = doc_total_r;
    row_len_nxt     = row_len_r;
    fail = 1'b0;
    e0   = 1'b0;
    mk   = 1'b0;
    tok0 = '0;
    att0 = 1'b0;
    seg0 = 1'b0;
    p0   = next_pos_r;

    // Length and truncation of a start transaction, in closed form
    rc     = (cfg.row_capacity > MAX_ROW_L) ? MAX_ROW_L : cfg.row_capacity;
    want   = (cfg.seq_limit == '0) ? DEFAULT_LEN_L : cfg.seq_limit;
    cap    = (want > {{(CNT_W-LEN_W){1'b0}}, rc}) ? rc : want[LEN_W-1:0];
    budget = cap - MARKER_SLOTS;
    half   = budget >> 1;
    sum    = {1'b0, query_count} + {1'b0, doc_count};
    over   = sum > {{(CNT_W+1-LEN_W){1'b0}}, budget};
    kq     = query_count[LEN_W-1:0];
    kd     = doc_count[LEN_W-1:0];
    if (over) begin
      if (cfg.trunc_mode == TRUNC_QUERY) begin
        if (query_count > {{(CNT_W-LEN_W){1'b0}}, budget}) begin
          kq = budget;
          kd = '0;
        end else begin
          kd = budget - query_count[LEN_W-1:0];
        end
      end else begin
        priority if (query_count >= doc_count &&
                     {doc_count, 1'b0} <= {{(CNT_W+1-LEN_W){1'b0}}, budget}) begin
          kq = budget - doc_count[LEN_W-1:0];
        end else if (doc_count > query_count &&
                     {query_count, 1'b0} <= {{(CNT_W+1-LEN_W){1'b0}}, budget}) begin
          kd = budget - query_count[LEN_W-1:0];
        end else begin
          kq = half;
          kd = budget - half;
        end
      end
    end

    unique case (cmd)
      CMD_START: begin
        fail = (cap < MARKER_SLOTS) || (over && cfg.trunc_mode == TRUNC_FAIL);
        p0   = '0;
        e0   = 1'b1;
        sep_done_nxt   = 1'b0;
        query_seen_nxt = '0;
        doc_seen_nxt   = '0;
        if (fail) begin
          pair_active_nxt = 1'b0;
          query_kept_nxt  = '0;
          doc_kept_nxt    = '0;
          query_total_nxt = '0;
          doc_total_nxt   = '0;
          row_len_nxt     = '0;
        end else begin
          pair_active_nxt = 1'b1;
          query_kept_nxt  = kq;
          doc_kept_nxt    = kd;
          query_total_nxt = query_count;
          doc_total_nxt   = doc_count;
          row_len_nxt     = rc;
          tok0 = cfg.cls_token;
          att0 = 1'b1;
          mk   = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (pair_active_r && !sep_done_r && query_seen_r < query_total_r) begin
          e0   = query_seen_r < {{(CNT_W-LEN_W){1'b0}}, query_kept_r};
          tok0 = token_value;
          att0 = 1'b1;
          query_seen_nxt = query_seen_r + CNT_W'(1);
          mk   = 1'b1;
        end
      end
      CMD_DOC: begin
        if (pair_active_r && sep_done_r && doc_seen_r < doc_total_r) begin
          e0   = doc_seen_r < {{(CNT_W-LEN_W){1'b0}}, doc_kept_r};
          tok0 = token_value;
          att0 = 1'b1;
          seg0 = 1'b1;
          doc_seen_nxt = doc_seen_r + CNT_W'(1);
          mk   = 1'b1;
        end
      end
      CMD_PAD: begin
        e0 = !pair_active_r && (next_pos_r < row_len_r);
      end
      default: ;
    endcase

    // Separator after the query, then the closing separator
    sep_pre = sep_done_nxt;
    m1 = mk && !sep_pre && (query_seen_nxt >= query_total_nxt);
    m2 = mk && (sep_pre || m1) && (doc_seen_nxt >= doc_total_nxt);
    if (m1) sep_done_nxt = 1'b1;
    if (m2) pair_active_nxt = 1'b0;

    p1 = p0 + LEN_W'(e0);
    p2 = p1 + LEN_W'(m1);
    next_pos_nxt = fail ? '0 : (p2 + LEN_W'(m2));

    group.mask          = {m2, m1, e0};
    group.status        = fail;
    group.packed_length = fail ? '0 : (MARKER_SLOTS + query_kept_nxt + doc_kept_nxt);

    group.slot[0].token    = tok0;
    group.slot[0].attend   = att0;
    group.slot[0].segment  = seg0;
    group.slot[0].position = p0[OPOS_W-1:0];
    group.slot[0].row_done = !fail && at_row_end(p0, row_len_nxt);

    group.slot[1].token    = cfg.sep_token;
    group.slot[1].attend   = 1'b1;
    group.slot[1].segment  = 1'b0;
    group.slot[1].position = p1[OPOS_W-1:0];
    group.slot[1].row_done = at_row_end(p1, row_len_nxt);

    group.slot[2].token    = cfg.sep_token;
    group.slot[2].attend   = 1'b1;
    group.slot[2].segment  = 1'b1;
    group.slot[2].position = p2[OPOS_W-1:0];
    group.slot[2].row_done = at_row_end(p2, row_len_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_active_r <= 1'b0;
      sep_done_r    <= 1'b0;
      query_kept_r  <= '0;
      doc_kept_r    <= '0;
      query_seen_r  <= '0;
      doc_seen_r    <= '0;
      query_total_r <= '0;
      doc_total_r   <= '0;
      next_pos_r    <= '0;
      row_len_r     <= '0;
    end else if (advance) begin
      pair_active_r <= pair_active_nxt;
      sep_done_r    <= sep_done_nxt;
      query_kept_r  <= query_kept_nxt;
      doc_kept_r    <= doc_kept_nxt;
      query_seen_r  <= query_seen_nxt;
      doc_seen_r    <= doc_seen_nxt;
      query_total_r <= query_total_nxt;
      doc_total_r   <= doc_total_nxt;
      next_pos_r    <= next_pos_nxt;
      row_len_r     <= row_len_nxt;
    end
  end

endmodule

>>> hw/rtl/tpsp_result_buf.sv
// tpsp_result_buf: result register holding one input transaction's row
// entries, draining them one per cycle unless stalled. Depends on tpsp_pkg.
module tpsp_result_buf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  tpsp_pkg::tpsp_group_t        group,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpsp_pkg::TOK_W-1:0]   out_token_out,
  output logic                         out_attend,
  output logic                         out_segment,
  output logic [tpsp_pkg::OPOS_W-1:0]  out_position,
  output logic                         out_status,
  output logic [tpsp_pkg::LEN_W-1:0]   out_packed_length,
  output logic                         out_last,
  output logic                         out_row_done
);
  import tpsp_pkg::*;

  logic [NSLOT-1:0]       mask_r, mask_nxt;
  tpsp_slot_t [NSLOT-1:0] slot_r;
  logic                   status_r;
  logic [LEN_W-1:0]       plen_r;
  logic [NSLOT-1:0]       low, rest;
  logic                   pop;
  tpsp_slot_t             cur;

  // Lowest pending entry goes out first
  assign low  = mask_r & (~mask_r + NSLOT'(1));
  assign rest = mask_r & ~low;
  assign pop  = out_valid && out_ready;
  assign free = (pop ? rest : mask_r) == '0;

  always_comb begin
    priority if (mask_r[0]) cur = slot_r[0];
    else if (mask_r[1])     cur = slot_r[1];
    else                    cur = slot_r[2];
  end

  assign out_valid         = mask_r != '0;
  assign out_token_out     = cur.token;
  assign out_attend        = cur.attend;
  assign out_segment       = cur.segment;
  assign out_position      = cur.position;
  assign out_row_done      = cur.row_done;
  assign out_status        = status_r;
  assign out_packed_length = plen_r;
  assign out_last          = rest == '0;

  always_comb begin
    mask_nxt = mask_r;
    if (load) mask_nxt = group.mask;
    else if (pop) mask_nxt = rest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r   <= group.slot;
      status_r <= group.status;
      plen_r   <= group.packed_length;
    end
  end

endmodule

>>> hw/rtl/token_pair_sequence_packer.sv
// token_pair_sequence_packer: top level of the query/document pair framer.
// Depends on tpsp_pkg, tpsp_cfg_regs, tpsp_frame and tpsp_result_buf.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, cmd, token, counts   | to block
//   out     | out_valid/out_ready, one row entry      | from block
//   cfg     | cfg_valid/cfg_ready, index, data        | to block
//
// One input transaction is registered, framed in one pass and loaded into
// the result register once that is free. While out_ready is high, that
// register drains one entry per cycle and holds an item until its last
// entry (0 to 3) drains, so the rate is one input transaction per cycle
// while items cause at most one entry each. Reset is synchronous and active
// low; it clears the pair state and loads the register defaults. A stall on
// out_ready holds the result register and backs up into in_ready.
module token_pair_sequence_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transactions
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tpsp_pkg::CMD_W-1:0]   in_cmd,
  input  logic signed [tpsp_pkg::TOK_W-1:0] in_token_value,
  input  logic [tpsp_pkg::CNT_W-1:0]   in_query_count,
  input  logic [tpsp_pkg::CNT_W-1:0]   in_doc_count,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [tpsp_pkg::TOK_W-1:0] out_token_out,
  output logic                         out_attend,
  output logic                         out_segment,
  output logic [tpsp_pkg::OPOS_W-1:0]  out_position,
  output logic                         out_status,
  output logic [tpsp_pkg::LEN_W-1:0]   out_packed_length,
  output logic                         out_last,
  output logic                         out_row_done,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpsp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [tpsp_pkg::TOK_W-1:0]   cfg_data
);
  import tpsp_pkg::*;

  tpsp_cfg_t   cfg;
  tpsp_group_t group;
  logic        buf_free;
  logic        advance;

  // Input register
  logic             in_vld_r;
  logic [CMD_W-1:0] cmd_r;
  logic [TOK_W-1:0] token_r;
  logic [CNT_W-1:0] query_count_r, doc_count_r;
  logic [TOK_W-1:0] token_out_w;

  // Advance the held transaction once the result register can take its entries
  assign advance  = in_vld_r && buf_free;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Hold the payload until it advances
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r         <= in_cmd;
      token_r       <= in_token_value;
      query_count_r <= in_query_count;
      doc_count_r   <= in_doc_count;
    end
  end

  tpsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpsp_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .advance     (advance),
    .cmd         (cmd_r),
    .token_value (token_r),
    .query_count (query_count_r),
    .doc_count   (doc_count_r),
    .group       (group)
  );

  tpsp_result_buf u_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (advance),
    .group             (group),
    .free              (buf_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_out     (token_out_w),
    .out_attend        (out_attend),
    .out_segment       (out_segment),
    .out_position      (out_position),
    .out_status        (out_status),
    .out_packed_length (out_packed_length),
    .out_last          (out_last),
    .out_row_done      (out_row_done)
  );

  assign out_token_out = $signed(token_out_w);

endmodule

>>> hw/rtl/tpsp_checker.sv
// tpsp_checker: port-level assertions for the packer, bound to the top level.
// Depends on tpsp_pkg and token_pair_sequence_packer.
module tpsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [tpsp_pkg::TOK_W-1:0] out_token_out,
  input logic                          out_attend,
  input logic                          out_segment,
  input logic                          out_status,
  input logic [tpsp_pkg::LEN_W-1:0]    out_packed_length,
  input logic                          out_last,
  input logic                          out_row_done
);
  import tpsp_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_out) && $stable(out_last))
    else $error("result changed while stalled");

  // A failed start is a single, empty entry
  a_fail_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && !out_attend && !out_row_done &&
                                out_packed_length == '0)
    else $error("failed start entry malformed");

  // Padding carries token zero in the query segment
  a_pad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_attend && !out_status |-> out_token_out == '0 && !out_segment)
    else $error("padding entry malformed");

  // Every real entry reports a length that holds at least the three markers
  a_plen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_attend |-> out_packed_length >= MARKER_SLOTS && !out_status)
    else $error("packed length below marker count");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind token_pair_sequence_packer tpsp_checker u_tpsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_token_out     (out_token_out),
  .out_attend        (out_attend),
  .out_segment       (out_segment),
  .out_status        (out_status),
  .out_packed_length (out_packed_length),
  .out_last          (out_last),
  .out_row_done      (out_row_done)
);
